// ----- rtl/axt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axt_pkg
// Shared types and constants of the address cross-reference tracker.
// ----------------------------------------------------------------------------
package axt_pkg;

  localparam int NUM_REGS = 32;
  localparam int REG_W    = $clog2(NUM_REGS);
  localparam int DATA_W   = 64;
  localparam int ADDR_W   = 4;

  typedef struct packed {
    logic        restart;
    logic [31:0] instr_word;
    logic [31:0] instr_offset;
    logic        last_word;
  } item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] query_value;
    logic        final_res;
  } result_t;

  // decoded instruction, register-file view
  typedef struct packed {
    logic             writes;
    logic             use_reg;
    logic             page;
    logic [REG_W-1:0] rd;
    logic [REG_W-1:0] src;
    logic [63:0]      addend;
  } dec_t;

endpackage

// ----- rtl/axt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module axt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/axt_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// axt_decode
// Decodes ADRP, ADD immediate, LDR unsigned offset, ADR and LDR literal into
// destination, source register and immediate addend.
// ----------------------------------------------------------------------------
module axt_decode (
  input  logic [31:0]   word,
  output axt_pkg::dec_t dec
);
  import axt_pkg::*;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADRP,
    OP_ADD,
    OP_LDR,
    OP_ADR,
    OP_LDRL
  } op_t;

  localparam logic [31:0] ADR_MASK  = 32'h9F00_0000;
  localparam logic [31:0] ADRP_VAL  = 32'h9000_0000;
  localparam logic [31:0] ADR_VAL   = 32'h1000_0000;
  localparam logic [31:0] OPC_MASK  = 32'hFF00_0000;
  localparam logic [31:0] ADD_VAL   = 32'h9100_0000;
  localparam logic [31:0] LDRL_VAL  = 32'h5800_0000;
  localparam logic [31:0] LDR_MASK  = 32'hF9C0_0000;
  localparam logic [31:0] LDR_VAL   = 32'hF940_0000;
  localparam logic [1:0]  SHIFT_12  = 2'd1;

  op_t         op;
  logic [20:0] adr_imm;
  logic [11:0] imm12;

  assign adr_imm = {word[23:5], word[30:29]};
  assign imm12   = word[21:10];

  always_comb begin
    if ((word & ADR_MASK) == ADRP_VAL) begin
      op = OP_ADRP;
    end else if ((word & OPC_MASK) == ADD_VAL) begin
      op = OP_ADD;
    end else if ((word & LDR_MASK) == LDR_VAL) begin
      op = OP_LDR;
    end else if ((word & ADR_MASK) == ADR_VAL) begin
      op = OP_ADR;
    end else if ((word & OPC_MASK) == LDRL_VAL) begin
      op = OP_LDRL;
    end else begin
      op = OP_NONE;
    end
  end

  always_comb begin
    dec.rd      = word[REG_W-1:0];
    dec.src     = word[REG_W-1:0];
    dec.writes  = 1'b1;
    dec.use_reg = 1'b0;
    dec.page    = 1'b0;
    dec.addend  = '0;
    unique case (op)
      OP_ADRP: begin
        dec.page   = 1'b1;
        dec.addend = {{31{adr_imm[20]}}, adr_imm, 12'b0};
      end
      OP_ADD: begin
        dec.use_reg = 1'b1;
        dec.src     = word[5 +: REG_W];
        if (word[23:22] == SHIFT_12) begin
          dec.addend = {40'b0, imm12, 12'b0};
        end else begin
          dec.addend = {52'b0, imm12};
        end
      end
      OP_LDR: begin
        dec.use_reg = 1'b1;
        dec.src     = word[5 +: REG_W];
        dec.addend  = {49'b0, imm12, 3'b0};
      end
      OP_ADR: begin
        dec.addend = {{43{adr_imm[20]}}, adr_imm};
      end
      OP_LDRL: begin
        dec.addend = {43'b0, word[23:5], 2'b0};
      end
      OP_NONE: begin
        // table unchanged: pass the destination's own value through
        dec.writes  = 1'b0;
        dec.use_reg = 1'b1;
      end
      default: begin
        dec.writes = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/arm64_address_xref_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm64_address_xref_tracker
// Tracks address-forming AArch64 instructions over a table of 64-bit
// register values and flags words whose destination reaches the target.
// ----------------------------------------------------------------------------
// The block accepts one instruction word every clock cycle unless an untaken
// result stalls it. The register table read fills the s1 stage register, and
// the add, compare and write-back fill the result register. The table sits in
// two copies of a 32 x 64 RAM with registered read, one serving the operand
// (or the destination of a word that forms no address) and one serving the
// query register; a forwarding register covers the write that lands at the
// edge of a read. Restart is handled by per-entry valid bits and clears the
// table within the same word, so no clearing pass follows reset. Registers
// are target_value at byte address 0 and query_reg at byte address 8.
// ----------------------------------------------------------------------------
module arm64_address_xref_tracker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  axt_pkg::item_t               item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output axt_pkg::result_t             result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [axt_pkg::ADDR_W-1:0]   paddr,
  input  logic [axt_pkg::DATA_W-1:0]   pwdata,
  output logic [axt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import axt_pkg::*;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_QUERY  = 1'b1;

  typedef struct packed {
    logic             restart;
    logic             last_word;
    dec_t             dec;
    logic [31:0]      base_off;
    logic [REG_W-1:0] qaddr;
  } stage_t;

  logic [63:0]      target_value;
  logic [REG_W-1:0] query_reg;
  logic             cfg_we;

  dec_t             dec;
  logic             accept;
  stage_t           s1;
  logic             s1_valid;
  logic             s1_adv;
  logic [NUM_REGS-1:0] valid;
  logic [NUM_REGS-1:0] valid_next;
  logic             fwd_valid;
  logic [REG_W-1:0] fwd_addr;
  logic [63:0]      fwd_data;
  logic [63:0]      rdata_src;
  logic [63:0]      rdata_qry;
  logic [63:0]      src_val;
  logic [63:0]      qry_val;
  logic [63:0]      base;
  logic [63:0]      sum;
  logic             wr_en;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_value <= '0;
      query_reg    <= '0;
    end else if (cfg_we) begin
      unique case (paddr[ADDR_W-1])
        REG_TARGET: target_value <= pwdata;
        REG_QUERY:  query_reg    <= pwdata[REG_W-1:0];
        default:    target_value <= target_value;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1])
      REG_TARGET: prdata = target_value;
      REG_QUERY:  prdata = {{(DATA_W-REG_W){1'b0}}, query_reg};
      default:    prdata = '0;
    endcase
  end

  // decode and table read
  axt_decode u_decode (
    .word (item.instr_word),
    .dec  (dec)
  );

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;
  assign accept     = item_valid && item_ready;
  assign wr_en      = s1_adv && s1.dec.writes;

  axt_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_ram_src (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.dec.rd),
    .wdata (sum),
    .re    (accept),
    .raddr (dec.src),
    .rdata (rdata_src)
  );

  axt_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_ram_qry (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1.dec.rd),
    .wdata (sum),
    .re    (accept),
    .raddr (query_reg),
    .rdata (rdata_qry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1.restart   <= item.restart;
      s1.last_word <= item.last_word;
      s1.dec       <= dec;
      s1.qaddr     <= query_reg;
      s1.base_off  <= dec.page ? {item.instr_offset[31:12], 12'b0}
                               : {item.instr_offset[31:2], 2'b0};
    end
  end

  // execute: resolve operands, add, compare, write back
  always_comb begin
    if (s1.restart || !valid[s1.dec.src]) begin
      src_val = '0;
    end else if (fwd_valid && fwd_addr == s1.dec.src) begin
      src_val = fwd_data;
    end else begin
      src_val = rdata_src;
    end
    if (s1.restart || !valid[s1.qaddr]) begin
      qry_val = '0;
    end else if (fwd_valid && fwd_addr == s1.qaddr) begin
      qry_val = fwd_data;
    end else begin
      qry_val = rdata_qry;
    end
  end

  assign base = s1.dec.use_reg ? src_val : {32'b0, s1.base_off};
  assign sum  = base + s1.dec.addend;

  always_comb begin
    valid_next = s1.restart ? '0 : valid;
    if (s1.dec.writes) begin
      valid_next[s1.dec.rd] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      fwd_valid <= 1'b0;
    end else if (s1_adv) begin
      valid <= valid_next;
      if (s1.dec.writes) begin
        fwd_valid <= 1'b1;
      end
    end
    if (wr_en) begin
      fwd_addr <= s1.dec.rd;
      fwd_data <= sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_adv) begin
      result.hit         <= (sum == target_value);
      result.query_value <= (s1.dec.writes && s1.dec.rd == s1.qaddr) ? sum : qry_val;
      result.final_res   <= s1.last_word;
    end
  end

  // checks
  a_write_sets_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(s1.dec.rd)])
    else $error("written entry not marked valid");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1.restart && !s1.dec.writes |=> valid == '0)
    else $error("restart left valid entries");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> fwd_valid && fwd_addr == $past(s1.dec.rd) && fwd_data == $past(sum))
    else $error("forwarding register missed a write");

  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> result_valid)
    else $error("advanced request produced no result");

endmodule
